[hw/rtl/iso22_pkg.sv]
`default_nettype none

package iso22_pkg;

    localparam int unsigned MAX_ESCAPE_LEN = 4;
    localparam int unsigned RES_MAX        = 5;
    localparam int unsigned RES_CNT_W      = 3;
    localparam int unsigned CFG_INDEX_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_VARIANT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EIGHT_BIT = 2'd1;

    localparam logic VARIANT_JP = 1'b0;
    localparam logic VARIANT_KR = 1'b1;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_DBCS = 2'd2;

    localparam logic ACT_DESIG  = 1'b0;
    localparam logic ACT_SELECT = 1'b1;

    localparam logic [1:0] CS_SI    = 2'd0;
    localparam logic [1:0] CS_SO    = 2'd1;
    localparam logic [1:0] CS_SI_GR = 2'd2;

    localparam logic [7:0] BYTE_ESC = 8'h1B;
    localparam logic [7:0] BYTE_SO  = 8'h0E;
    localparam logic [7:0] BYTE_SI  = 8'h0F;
    localparam logic [7:0] BYTE_SPACE   = 8'h21;
    localparam logic [7:0] BYTE_DEL     = 8'h7E;
    localparam logic [7:0] BYTE_GR_LOW  = 8'hA0;

    localparam logic [15:0] JIS_YEN_IN      = 16'h005C;
    localparam logic [15:0] JIS_YEN_OUT     = 16'h00A5;
    localparam logic [15:0] JIS_OVERLINE_IN = 16'h007E;
    localparam logic [15:0] JIS_OVERLINE_OUT = 16'h203E;

    typedef struct packed {
        logic [2:0]      len;
        logic            act;
        logic [1:0]      cont;
        logic [1:0]      set;
        logic [3:0][7:0] seq;
    } esc_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [1:0]  sub_set;
    } res_t;

    typedef struct packed {
        res_t [RES_MAX-1:0]   items;
        logic [RES_CNT_W-1:0] count;
    } res_list_t;

    function automatic esc_t esc_lookup(input logic variant, input logic [1:0] idx);
        esc_t e;
        e = '0;
        case ({variant, idx})
            3'b000: e = '{len: 3'd3, act: ACT_DESIG, cont: 2'd0, set: 2'd2,
                          seq: {8'h00, 8'h40, 8'h24, BYTE_ESC}};
            3'b001: e = '{len: 3'd3, act: ACT_DESIG, cont: 2'd0, set: 2'd2,
                          seq: {8'h00, 8'h42, 8'h24, BYTE_ESC}};
            3'b010: e = '{len: 3'd3, act: ACT_DESIG, cont: 2'd0, set: 2'd0,
                          seq: {8'h00, 8'h42, 8'h28, BYTE_ESC}};
            3'b011: e = '{len: 3'd3, act: ACT_DESIG, cont: 2'd0, set: 2'd1,
                          seq: {8'h00, 8'h4A, 8'h28, BYTE_ESC}};
            3'b100: e = '{len: 3'd1, act: ACT_SELECT, cont: 2'd1, set: 2'd0,
                          seq: {8'h00, 8'h00, 8'h00, BYTE_SO}};
            3'b101: e = '{len: 3'd1, act: ACT_SELECT, cont: 2'd0, set: 2'd0,
                          seq: {8'h00, 8'h00, 8'h00, BYTE_SI}};
            3'b110: e = '{len: 3'd4, act: ACT_DESIG, cont: 2'd1, set: 2'd1,
                          seq: {8'h43, 8'h29, 8'h24, BYTE_ESC}};
            default: e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] set_bytes(input logic variant, input logic [1:0] sub);
        logic [1:0] n;
        n = 2'd0;
        case ({variant, sub})
            3'b000: n = 2'd1;
            3'b001: n = 2'd1;
            3'b010: n = 2'd2;
            3'b100: n = 2'd1;
            3'b101: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/iso2022_subset_decoder.sv]
// path to first result: input register, then result buffer (a full buffer stalls)
// throughput: one byte per cycle while the buffer is free; a byte with k results
// holds it until all are taken; one with none (escape in progress) leaves it free
// reset: aresetn synchronous active low, clears decoder state and config to ISO-2022-JP
`default_nettype none

module iso2022_subset_decoder
    import iso22_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,    // in_byte
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [15:0]                 m_tdata,    // value
    output logic [3:0]                  m_tuser,    // kind, sub_set
    output logic                        m_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                   cfg_data
);

    logic       variant_reg;
    logic       eight_bit_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       buf_free;
    logic       load;
    res_list_t  res_list;

    assign cfg_ready = 1'b1;
    assign load      = in_valid_reg && buf_free;
    assign s_tready  = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg   <= VARIANT_JP;
            eight_bit_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_VARIANT:   variant_reg   <= cfg_data;
                CFG_EIGHT_BIT: eight_bit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    iso22_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .variant        (variant_reg),
        .eight_bit_mode (eight_bit_reg),
        .step           (load),
        .in_byte        (in_byte_reg),
        .res_list       (res_list)
    );

    iso22_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res_list (res_list),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/iso22_decode.sv]
`default_nettype none

module iso22_decode
    import iso22_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      variant,
    input  wire logic      eight_bit_mode,
    input  wire logic      step,
    input  wire logic [7:0] in_byte,
    output res_list_t      res_list
);

    logic [1:0]      esc_idx_reg, esc_idx_next;
    logic [2:0]      esc_cnt_reg, esc_cnt_next;
    logic            started_reg;
    logic [1:0]      cont_sel_reg, cont_sel_next;
    logic [1:0]      char_cnt_reg, char_cnt_next;
    logic [15:0]     char_acc_reg, char_acc_next;
    logic [3:0][1:0] desig_reg, desig_next;

    logic [1:0]      cs, cs_w, cont, sub, need;
    logic [1:0]      cbc, cbc_w;
    logic [15:0]     acc, acc_w, chr, uval;
    logic [3:0][1:0] dsg;
    logic [2:0]      len;
    logic [2:0]      n;
    logic [2:0]      k;
    esc_t            ref_e, hit_e;
    logic            hit;
    logic [1:0]      hit_i;
    logic            esc_path, ctrl_byte;
    res_list_t       list;

    function automatic logic esc_hit(input logic v, input logic [1:0] i, input esc_t r,
                                     input logic [2:0] cnt, input logic [7:0] b);
        esc_t e;
        logic ok;
        e  = esc_lookup(v, i);
        ok = (e.len <= 3'(MAX_ESCAPE_LEN)) && (e.len > cnt);
        for (int j = 0; j < 4; j++) begin
            if ((3'(j) < cnt) && (e.seq[j] != r.seq[j])) begin
                ok = 1'b0;
            end
        end
        if (e.seq[cnt[1:0]] != b) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    always_comb begin
        cs  = started_reg ? cont_sel_reg : CS_SI;
        cbc = started_reg ? char_cnt_reg : 2'd0;
        acc = started_reg ? char_acc_reg : 16'd0;
        for (int d = 0; d < 4; d++) begin
            if (started_reg) begin
                dsg[d] = desig_reg[d];
            end else begin
                dsg[d] = (variant == VARIANT_KR && d == 1) ? 2'd1 : 2'd0;
            end
        end

        esc_idx_next  = esc_idx_reg;
        esc_cnt_next  = esc_cnt_reg;
        cont_sel_next = cs;
        char_cnt_next = cbc;
        char_acc_next = acc;
        desig_next    = dsg;
        list          = '0;
        k             = '0;

        n     = esc_cnt_reg;
        ref_e = esc_lookup(variant, esc_idx_reg);
        hit   = 1'b0;
        hit_i = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (esc_hit(variant, 2'(i), ref_e, n, in_byte)) begin
                hit   = 1'b1;
                hit_i = 2'(i);
            end
        end
        hit_e = esc_lookup(variant, hit_i);

        esc_path  = (esc_cnt_reg != 3'd0) || (in_byte == BYTE_SO) ||
                    (in_byte == BYTE_SI) || (in_byte == BYTE_ESC);
        ctrl_byte = (in_byte < BYTE_SPACE) ||
                    ((in_byte > BYTE_DEL) && (!eight_bit_mode || in_byte < BYTE_GR_LOW));

        cs_w  = cs;
        cbc_w = cbc;
        acc_w = acc;
        chr   = '0;
        len   = '0;
        cont  = '0;
        sub   = '0;
        need  = '0;
        uval  = '0;

        if (esc_path) begin
            if (cbc != 2'd0) begin
                list.items[k] = '{kind: KIND_ERR, value: 16'd0, sub_set: 2'd0};
                k             = k + 3'd1;
                char_cnt_next = 2'd0;
                char_acc_next = 16'd0;
                cont_sel_next = {1'b0, cs[0]};
            end
            if (!hit) begin
                for (int j = 0; j < 4; j++) begin
                    if (3'(j) < n) begin
                        list.items[k] = '{kind: KIND_CHAR, value: {8'd0, ref_e.seq[j]},
                                          sub_set: 2'd0};
                        k             = k + 3'd1;
                    end
                end
                list.items[k] = '{kind: KIND_CHAR, value: {8'd0, in_byte}, sub_set: 2'd0};
                k             = k + 3'd1;
                esc_cnt_next  = 3'd0;
                esc_idx_next  = 2'd0;
            end else if ((n + 3'd1) == hit_e.len) begin
                esc_cnt_next = 3'd0;
                esc_idx_next = 2'd0;
                if (hit_e.act == ACT_SELECT) begin
                    cont_sel_next = {1'b0, hit_e.cont[0]};
                end else begin
                    desig_next[hit_e.cont] = hit_e.set;
                end
            end else begin
                esc_idx_next = hit_i;
                esc_cnt_next = n + 3'd1;
            end
        end else if (ctrl_byte) begin
            if (cbc != 2'd0) begin
                list.items[k] = '{kind: KIND_ERR, value: 16'd0, sub_set: 2'd0};
                k             = k + 3'd1;
                char_cnt_next = 2'd0;
                char_acc_next = 16'd0;
                cont_sel_next = {1'b0, cs[0]};
            end
            list.items[k] = '{kind: KIND_CHAR, value: {8'd0, in_byte}, sub_set: 2'd0};
            k             = k + 3'd1;
        end else begin
            if (eight_bit_mode) begin
                if ((cs == CS_SI_GR && !in_byte[7]) ||
                    (cs != CS_SI && cs != CS_SI_GR && in_byte[7])) begin
                    list.items[k] = '{kind: KIND_ERR, value: 16'd0, sub_set: 2'd0};
                    k             = k + 3'd1;
                    cbc_w         = 2'd0;
                    acc_w         = 16'd0;
                    cs_w          = {1'b0, cs[0]};
                end
                if (cs == CS_SI && in_byte[7]) begin
                    cs_w = cs_w | CS_SI_GR;
                end
            end
            chr  = {acc_w[7:0], 1'b0, in_byte[6:0]};
            len  = {1'b0, cbc_w} + 3'd1;
            cont = (cs_w > 2'd1) ? (cs_w >> 1) : cs_w;
            sub  = dsg[cont];
            need = set_bytes(variant, sub);
            uval = chr;
            if (variant == VARIANT_JP && sub == 2'd1) begin
                if (chr == JIS_YEN_IN) begin
                    uval = JIS_YEN_OUT;
                end else if (chr == JIS_OVERLINE_IN) begin
                    uval = JIS_OVERLINE_OUT;
                end
            end
            if (len >= {1'b0, need}) begin
                if (need == 2'd0) begin
                    list.items[k] = '{kind: KIND_ERR, value: 16'd0, sub_set: 2'd0};
                end else if (need == 2'd2) begin
                    list.items[k] = '{kind: KIND_DBCS, value: chr, sub_set: sub};
                end else begin
                    list.items[k] = '{kind: KIND_CHAR, value: uval, sub_set: sub};
                end
                k             = k + 3'd1;
                char_acc_next = 16'd0;
                char_cnt_next = 2'd0;
                cont_sel_next = {1'b0, cs_w[0]};
            end else begin
                char_acc_next = chr;
                char_cnt_next = len[1:0];
                cont_sel_next = cs_w;
            end
        end
        list.count = k;
    end

    assign res_list = list;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_idx_reg  <= '0;
            esc_cnt_reg  <= '0;
            started_reg  <= 1'b0;
            cont_sel_reg <= CS_SI;
            char_cnt_reg <= '0;
            char_acc_reg <= '0;
            desig_reg    <= '0;
        end else if (step) begin
            esc_idx_reg  <= esc_idx_next;
            esc_cnt_reg  <= esc_cnt_next;
            started_reg  <= 1'b1;
            cont_sel_reg <= cont_sel_next;
            char_cnt_reg <= char_cnt_next;
            char_acc_reg <= char_acc_next;
            desig_reg    <= desig_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_esc_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_cnt_reg <= 3'd3)
        else $error("escape prefix longer than any table entry");

    a_char_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        char_cnt_reg <= 2'd1)
        else $error("partial character holds more than one byte");

    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (char_cnt_reg == 2'd0) |-> (char_acc_reg == 16'd0))
        else $error("stale accumulator with no partial character");
`endif

endmodule

`default_nettype wire

[hw/rtl/iso22_outbuf.sv]
`default_nettype none

module iso22_outbuf
    import iso22_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire res_list_t   res_list,
    output logic             free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // value
    output logic [3:0]       m_tuser,   // kind, sub_set
    output logic             m_tlast
);

    res_t [RES_MAX-1:0]   items_reg;
    logic [RES_CNT_W-1:0] count_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 pop;
    logic                 at_last;
    res_t                 cur;

    assign at_last  = (idx_reg == (count_reg - 3'd1));
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign free     = !m_tvalid || (pop && at_last);
    assign cur      = items_reg[idx_reg];
    assign m_tdata  = cur.value;
    assign m_tuser  = {cur.sub_set, cur.kind};
    assign m_tlast  = at_last;

    always_ff @(posedge aclk) begin
        if (load) begin
            items_reg <= res_list.items;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else if (load) begin
            count_reg <= res_list.count;
            idx_reg   <= '0;
        end else if (pop) begin
            if (at_last) begin
                count_reg <= '0;
                idx_reg   <= '0;
            end else begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (idx_reg < count_reg))
        else $error("read index past the buffered results");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(RES_MAX))
        else $error("result count beyond buffer depth");
`endif

endmodule

`default_nettype wire

[verif/iso22_checker.sv]
`timescale 1ns / 100ps

module iso22_checker
    import iso22_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [15:0]            m_tdata,
    input  logic [3:0]             m_tuser,
    input  logic                   m_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [1:0]  sub_set;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [2:0]      len;
        logic            act;
        logic [1:0]      cont;
        logic [1:0]      set;
        logic [0:3][7:0] seq;
    } esc_row_t;

    logic        variant;
    logic        eight_mode;
    logic        started;
    logic [1:0]  esc_idx;
    logic [2:0]  esc_cnt;
    logic [2:0]  cont_sel;
    logic [1:0]  part_cnt;
    logic [15:0] part_accum;
    logic [1:0]  desig [4];
    token_t      step_q[$];
    token_t      decoded_q[$];

    function automatic esc_row_t esc_row(input logic v, input logic [1:0] i);
        esc_row_t r;
        r = '0;
        if (v == VARIANT_JP) begin
            r.len = 3'd3;
            r.act = ACT_DESIG;
            case (i)
                2'd0: begin
                    r.set = 2'd2;
                    r.seq = {BYTE_ESC, 8'h24, 8'h40, 8'h00};
                end
                2'd1: begin
                    r.set = 2'd2;
                    r.seq = {BYTE_ESC, 8'h24, 8'h42, 8'h00};
                end
                2'd2: begin
                    r.set = 2'd0;
                    r.seq = {BYTE_ESC, 8'h28, 8'h42, 8'h00};
                end
                default: begin
                    r.set = 2'd1;
                    r.seq = {BYTE_ESC, 8'h28, 8'h4A, 8'h00};
                end
            endcase
        end else begin
            case (i)
                2'd0: begin
                    r.len = 3'd1;
                    r.act = ACT_SELECT;
                    r.cont = 2'd1;
                    r.seq = {BYTE_SO, 8'h00, 8'h00, 8'h00};
                end
                2'd1: begin
                    r.len = 3'd1;
                    r.act = ACT_SELECT;
                    r.seq = {BYTE_SI, 8'h00, 8'h00, 8'h00};
                end
                2'd2: begin
                    r.len = 3'd4;
                    r.act = ACT_DESIG;
                    r.cont = 2'd1;
                    r.set = 2'd1;
                    r.seq = {BYTE_ESC, 8'h24, 8'h29, 8'h43};
                end
                default: r = '0;
            endcase
        end
        return r;
    endfunction

    // bytes per character of a subcharset, zero when undefined
    function automatic int char_len(input logic v, input logic [1:0] sub);
        if (v == VARIANT_JP)
            return (sub == 2'd2) ? 2 : ((sub == 2'd3) ? 0 : 1);
        return (sub == 2'd0) ? 1 : ((sub == 2'd1) ? 2 : 0);
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [15:0] value,
                                 input logic [1:0] sub);
        token_t t;
        t = '{kind: kind, value: value, sub_set: sub, last: 1'b0};
        if (step_q.size() < RES_MAX)
            step_q.push_back(t);
    endfunction

    function automatic void cut_char();
        part_cnt = '0;
        part_accum = '0;
        cont_sel = cont_sel & 3'd1;
        emit(KIND_ERR, 16'h0000, 2'd0);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        esc_row_t   held_row;
        esc_row_t   row;
        logic       v;
        logic       ok;
        int         held;
        int         hit;
        int         i;
        int         j;
        int         len;
        int         need;
        logic [2:0] cs;
        logic [1:0] sub;
        logic [23:0] chr;
        logic [15:0] u;

        v = variant;
        step_q.delete();
        if (!started) begin
            started = 1'b1;
            cont_sel = '0;
            part_cnt = '0;
            part_accum = '0;
            for (i = 0; i < 4; i++)
                desig[i] = 2'd0;
            if (v == VARIANT_KR)
                desig[1] = 2'd1;
        end

        if (esc_cnt != 0 || b == BYTE_SO || b == BYTE_SI || b == BYTE_ESC) begin
            held = esc_cnt;
            held_row = esc_row(v, esc_idx);
            if (part_cnt != 0)
                cut_char();
            hit = -1;
            for (i = 0; i < 4; i++) begin
                row = esc_row(v, i[1:0]);
                ok = (row.len <= MAX_ESCAPE_LEN) && (row.len > held) && (row.seq[held] == b);
                for (j = 0; j < held; j++)
                    if (row.seq[j] != held_row.seq[j])
                        ok = 1'b0;
                if (ok && hit < 0)
                    hit = i;
            end
            if (hit < 0) begin
                for (j = 0; j < held; j++)
                    emit(KIND_CHAR, {8'h00, held_row.seq[j]}, 2'd0);
                emit(KIND_CHAR, {8'h00, b}, 2'd0);
                esc_cnt = '0;
                esc_idx = '0;
            end else begin
                row = esc_row(v, hit[1:0]);
                if (held + 1 == row.len) begin
                    esc_cnt = '0;
                    esc_idx = '0;
                    if (row.act == ACT_SELECT)
                        cont_sel = {2'b00, row.cont[0]};
                    else
                        desig[row.cont] = row.set;
                end else begin
                    esc_idx = hit[1:0];
                    esc_cnt = 3'(held + 1);
                end
            end
        end else if (b < 8'h21 || (b > 8'h7E && (!eight_mode || b < 8'hA0))) begin
            if (part_cnt != 0)
                cut_char();
            emit(KIND_CHAR, {8'h00, b}, 2'd0);
        end else begin
            if (eight_mode) begin
                cs = cont_sel;
                if ((cs == 3'd2 && !b[7]) || (cs != 3'd0 && cs != 3'd2 && b[7]))
                    cut_char();
                if (cs == 3'd0 && b[7])
                    cont_sel = cont_sel | 3'd2;
            end
            chr = {part_accum, 1'b0, b[6:0]};
            len = part_cnt + 1;
            cs = cont_sel;
            if (cs > 3'd1)
                cs = cs >> 1;
            sub = desig[cs[1:0]];
            need = char_len(v, sub);
            if (len >= need) begin
                if (need == 0) begin
                    emit(KIND_ERR, 16'h0000, 2'd0);
                end else if (need == 2) begin
                    emit(KIND_DBCS, chr[15:0], sub);
                end else begin
                    u = chr[15:0];
                    if (v == VARIANT_JP && sub == 2'd1) begin
                        if (u == JIS_YEN_IN)
                            u = JIS_YEN_OUT;
                        else if (u == JIS_OVERLINE_IN)
                            u = JIS_OVERLINE_OUT;
                    end
                    emit(KIND_CHAR, u, sub);
                end
                chr = '0;
                len = 0;
                cont_sel = cont_sel & 3'd1;
            end
            part_accum = chr[15:0];
            part_cnt = len[1:0];
        end

        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[k])
            decoded_q.push_back(step_q[k]);
    endfunction

    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            variant = VARIANT_JP;
            eight_mode = 1'b0;
            started = 1'b0;
            esc_idx = '0;
            esc_cnt = '0;
            cont_sel = '0;
            part_cnt = '0;
            part_accum = '0;
            for (int i = 0; i < 4; i++)
                desig[i] = 2'd0;
            decoded_q.delete();
            errors = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_VARIANT)
                    variant = cfg_data;
                else if (cfg_index == CFG_EIGHT_BIT)
                    eight_mode = cfg_data;
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none, actual kind %0d value %h",
                             $time, m_tuser[1:0], m_tdata);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tuser[1:0] !== want.kind) begin
                        errors++;
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, m_tuser[1:0]);
                    end
                    if (m_tdata !== want.value) begin
                        errors++;
                        $display("%0t: value expected %h actual %h",
                                 $time, want.value, m_tdata);
                    end
                    if (m_tuser[3:2] !== want.sub_set) begin
                        errors++;
                        $display("%0t: sub_set expected %0d actual %0d",
                                 $time, want.sub_set, m_tuser[3:2]);
                    end
                    if (m_tlast !== want.last) begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            pending = decoded_q.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import iso22_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;
    logic [3:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic                   cfg_data;

    int   errors;
    int   pending;
    int   n_sent = 0;
    logic gaps_on = 1'b1;
    logic hold_req = 1'b0;
    logic cur_variant = VARIANT_JP;
    logic cur_eight = 1'b0;

    iso2022_subset_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    iso22_checker u_chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    initial begin
        #400000;
        $display("tb_top: done, errors");
        $finish;
    end

    // result sink, with one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (80) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // first byte in the highest bits
    task automatic send_bytes(input logic [127:0] seq, input int n);
        for (int k = 0; k < n; k++)
            send_byte(seq[8 * (n - 1 - k) +: 8]);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_VARIANT)
            cur_variant = val;
        else
            cur_eight = val;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_token();
        int         pick;
        int         k;
        int         n;
        logic       gr;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 15) begin
            k = $urandom_range(3);
            if (cur_variant == VARIANT_JP) begin
                case (k)
                    0: send_bytes(128'({BYTE_ESC, 8'h24, 8'h40}), 3);
                    1: send_bytes(128'({BYTE_ESC, 8'h24, 8'h42}), 3);
                    2: send_bytes(128'({BYTE_ESC, 8'h28, 8'h42}), 3);
                    default: send_bytes(128'({BYTE_ESC, 8'h28, 8'h4A}), 3);
                endcase
            end else begin
                case (k)
                    0: send_byte(BYTE_SO);
                    1: send_byte(BYTE_SI);
                    2: send_byte(BYTE_SO);
                    default: send_bytes(128'({BYTE_ESC, 8'h24, 8'h29, 8'h43}), 4);
                endcase
            end
        end else if (pick < 70) begin
            // character run, whole pairs so double-byte sets complete
            n = 2 * $urandom_range(4, 1);
            gr = cur_eight && ($urandom_range(2) == 0);
            for (int i = 0; i < n; i++)
                send_byte(gr ? 8'($urandom_range(255, 160)) : 8'($urandom_range(126, 33)));
        end else if (pick < 80) begin
            k = $urandom_range(2);
            if (k == 0)
                send_byte(8'($urandom_range(32, 0)));
            else if (k == 1)
                send_byte(8'($urandom_range(159, 127)));
            else
                send_byte(8'($urandom_range(255, 160)));
        end else if (pick < 90) begin
            // broken escape
            send_byte(BYTE_ESC);
            repeat ($urandom_range(2)) begin
                k = $urandom_range(2);
                b = (k == 0) ? 8'h24 : ((k == 1) ? 8'h28 : 8'h29);
                send_byte(b);
            end
            send_byte(8'($urandom_range(255)));
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = n_sent + count;
        while (n_sent < target)
            send_token();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_VARIANT;
        cfg_data <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // korean set loaded on the first byte, gr bytes as controls
        write_reg(CFG_VARIANT, VARIANT_KR);
        write_reg(CFG_EIGHT_BIT, 1'b0);
        send_bytes(128'({8'h41, BYTE_SO, 8'h30, 8'h21, 8'h30, 8'h0A, 8'hFF, BYTE_SI,
                         BYTE_ESC, 8'h24, 8'h58, BYTE_ESC, 8'h24}), 13);
        settle();

        // held escape prefix read from the japanese table
        write_reg(CFG_VARIANT, VARIANT_JP);
        write_reg(CFG_EIGHT_BIT, 1'b1);
        send_bytes(128'({8'h4A, 8'h5C, 8'h7E, BYTE_ESC, 8'h24, 8'h42, 8'h30, 8'h21,
                         8'hB0}), 9);
        settle();

        // eight-bit mismatches, character cut by escape
        write_reg(CFG_VARIANT, VARIANT_KR);
        send_bytes(128'({8'h41, 8'hB0, 8'h41, BYTE_SO, 8'hB0, BYTE_ESC, 8'h24, 8'h29,
                         8'h43}), 9);
        settle();

        write_reg(CFG_VARIANT, VARIANT_JP);
        write_reg(CFG_EIGHT_BIT, 1'b0);
        run_random(100);
        settle();

        write_reg(CFG_VARIANT, VARIANT_KR);
        write_reg(CFG_EIGHT_BIT, 1'b1);
        run_random(30);
        hold_req = 1'b1;
        run_random(70);
        settle();

        write_reg(CFG_VARIANT, VARIANT_JP);
        gaps_on = 1'b0;
        run_random(100);
        settle();
        gaps_on = 1'b1;

        write_reg(CFG_VARIANT, VARIANT_KR);
        write_reg(CFG_EIGHT_BIT, 1'b0);
        run_random(80);
        settle();
        repeat (6) @(posedge aclk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/iso22_pkg.sv
hw/rtl/iso22_decode.sv
hw/rtl/iso22_outbuf.sv
hw/rtl/iso2022_subset_decoder.sv
verif/iso22_checker.sv
verif/tb_top.sv
